### design/bnse_pkg.sv
package bnse_pkg;

    localparam logic [1:0] ALPHA_B16    = 2'd0;
    localparam logic [1:0] ALPHA_B32    = 2'd1;
    localparam logic [1:0] ALPHA_B64    = 2'd2;
    localparam logic [1:0] ALPHA_B64URL = 2'd3;

    localparam logic CFG_ALPHABET  = 1'b0;
    localparam logic CFG_PAD_GROUP = 1'b1;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [3:0] MAX_GROUP   = 4'd8;
    localparam logic [3:0] MAX_RESULTS = 4'd8;
    localparam logic [3:0] BYTE_BITS   = 4'd8;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    function automatic logic [3:0] sym_width(input logic [1:0] alpha);
        logic [3:0] w;
        case (alpha)
            ALPHA_B16: w = 4'd4;
            ALPHA_B32: w = 4'd5;
            default:   w = 4'd6;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] sym_char(input logic [1:0] alpha, input logic [5:0] v);
        logic [7:0] c;
        c = 8'h00;
        case (alpha)
            ALPHA_B16:
            begin
                if (v[3:0] < 4'd10)
                    c = 8'h30 + {4'b0, v[3:0]};
                else
                    c = 8'h37 + {4'b0, v[3:0]};
            end
            ALPHA_B32:
            begin
                if (v[4:0] < 5'd26)
                    c = 8'h41 + {3'b0, v[4:0]};
                else
                    c = 8'h18 + {3'b0, v[4:0]};
            end
            default:
            begin
                if (v < 6'd26)
                    c = 8'h41 + {2'b0, v};
                else if (v < 6'd52)
                    c = 8'h47 + {2'b0, v};
                else if (v < 6'd62)
                    c = {2'b0, v} - 8'd4;
                else if (v == 6'd62)
                    c = (alpha == ALPHA_B64URL) ? 8'h2D : 8'h2B;
                else
                    c = (alpha == ALPHA_B64URL) ? 8'h5F : 8'h2F;
            end
        endcase
        return c;
    endfunction

endpackage

### design/bnse_front.sv
module bnse_front
    import bnse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        push;
    logic        pop;

    assign s_axis_tready = (fill_reg != 2'd2);
    assign q_valid       = (fill_reg != 2'd0);
    assign q_item        = entry_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{last: s_axis_tlast, data: s_axis_tdata};
        end
    end

endmodule

### design/bnse_back.sv
module bnse_back
    import bnse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] alphabet_select,
    input  logic [3:0] pad_group,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // symbol_char[7:0]
    output logic       m_axis_tlast
);

    logic [12:0] acc_reg;
    logic [12:0] acc_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [3:0]  n_reg;
    logic [3:0]  n_next;
    logic        last_reg;
    logic        last_next;
    logic        busy_reg;
    logic        busy_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;

    logic [3:0]  width;
    logic [3:0]  group;
    logic        slot_free;
    logic        emit;
    logic        sym_avail;
    logic        flush;
    logic [12:0] sym_bits;
    logic [7:0]  sym_out;
    logic [3:0]  count_post;
    logic [2:0]  phase_post;
    logic [3:0]  phase_inc;
    logic [3:0]  n_post;
    logic        pads_more;
    logic        more;
    logic        done;
    logic        clear;
    logic        load;
    logic [12:0] base_acc;
    logic [3:0]  base_count;
    logic [2:0]  base_phase;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        width     = sym_width(alphabet_select);
        group     = (pad_group > MAX_GROUP) ? MAX_GROUP : pad_group;
        slot_free = !out_valid_reg || m_axis_tready;
        emit      = busy_reg && slot_free;
        sym_avail = (count_reg >= width);
        flush     = !sym_avail && last_reg && (count_reg != 4'd0);

        if (sym_avail)
            sym_bits = acc_reg >> (count_reg - width);
        else
            sym_bits = acc_reg << (width - count_reg);

        if (sym_avail || flush)
            sym_out = sym_char(alphabet_select, sym_bits[5:0]);
        else
            sym_out = PAD_CHAR;

        count_post = sym_avail ? (count_reg - width) : 4'd0;
        phase_inc  = {1'b0, phase_reg} + 4'd1;
        if ((group == 4'd0) || (phase_inc >= group))
            phase_post = 3'd0;
        else
            phase_post = phase_inc[2:0];
        n_post = n_reg + 4'd1;

        pads_more = (group != 4'd0) && (phase_post != 3'd0) && ({1'b0, phase_post} < group);
        more      = (n_post < MAX_RESULTS)
                    && ((count_post >= width)
                        || (last_reg && ((count_post != 4'd0) || pads_more)));
        done      = emit && !more;
        clear     = done && last_reg;
        load      = q_valid && (!busy_reg || done);
        q_ready   = !busy_reg || done;

        base_acc   = clear ? 13'd0 : acc_reg;
        base_count = clear ? 4'd0 : (emit ? count_post : count_reg);
        base_phase = clear ? 3'd0 : (emit ? phase_post : phase_reg);

        acc_next   = load ? {base_acc[4:0], q_item.data} : base_acc;
        count_next = load ? (base_count + BYTE_BITS) : base_count;
        phase_next = base_phase;
        n_next     = load ? 4'd0 : (emit ? n_post : n_reg);
        last_next  = load ? q_item.last : last_reg;
        busy_next  = load ? 1'b1 : (done ? 1'b0 : busy_reg);

        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 13'd0;
            count_reg     <= 4'd0;
            phase_reg     <= 3'd0;
            n_reg         <= 4'd0;
            last_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= sym_out;
            out_last_reg <= last_reg && !more;
        end
    end

endmodule

### design/base_n_symbol_encoder_top.sv
// An accepted byte goes through the front queue, the accumulator and the output register.
// Throughput: one symbol per cycle, set by the single output register, unless the receiver
// stalls; each byte yields one to eight symbols or '=' characters.
// Reset (rst_n low, asynchronous): queue and accumulator empty, base64 standard selected,
// pad group 4.
module base_n_symbol_encoder_top
    import bnse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // symbol_char[7:0]
    output logic       m_axis_tlast
);

    logic [1:0] alphabet_reg;
    logic [3:0] pad_group_reg;
    logic       q_valid;
    logic       q_ready;
    item_t      q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_reg  <= ALPHA_B64;
            pad_group_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHABET:  alphabet_reg  <= cfg_data[1:0];
                CFG_PAD_GROUP: pad_group_reg <= cfg_data;
                default:       pad_group_reg <= pad_group_reg;
            endcase
        end
    end

    bnse_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    bnse_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .alphabet_select (alphabet_reg),
        .pad_group       (pad_group_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast)
    );

endmodule

### dv/bnse_symbol_checker.sv
module bnse_symbol_checker
    import bnse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // symbol_char[7:0]
    input  logic       m_axis_tlast,
    output int         mismatches,
    output int         symbols_due
);

    typedef struct {
        logic [7:0] code;
        logic       last;
    } symbol_t;

    localparam logic [8*16-1:0] B16_SET = "0123456789ABCDEF";
    localparam logic [8*32-1:0] B32_SET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    localparam logic [8*64-1:0] B64_SET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                           "abcdefghijklmnopqrstuvwxyz",
                                           "0123456789+/"};

    logic [1:0]  alphabet;
    logic [3:0]  pad_size;
    logic [12:0] held_bits;
    logic [3:0]  held_count;
    logic [2:0]  group_phase;
    symbol_t     expected_symbols[$];

    function automatic logic [7:0] symbol_code(input logic [5:0] v);
        case (alphabet)
            ALPHA_B16:    return B16_SET[8*(15 - v[3:0]) +: 8];
            ALPHA_B32:    return B32_SET[8*(31 - v[4:0]) +: 8];
            ALPHA_B64URL: return (v == 6'd62) ? "-" : (v == 6'd63) ? "_" : B64_SET[8*(63 - v) +: 8];
            default:      return B64_SET[8*(63 - v) +: 8];
        endcase
    endfunction

    function automatic logic [2:0] next_phase(input int group);
        if (group == 0 || int'(group_phase) + 1 >= group)
            return 3'd0;
        return group_phase + 3'd1;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] symbol stream: %s", $time, what);
        mismatches++;
    endtask

    task automatic encode_byte(input logic [7:0] data_in, input logic last_in);
        int      width;
        int      group;
        int      n;
        int      pads;
        int      flushed;
        symbol_t s;
        width = (alphabet == ALPHA_B16) ? 4 : (alphabet == ALPHA_B32) ? 5 : 6;
        group = (pad_size > MAX_GROUP) ? int'(MAX_GROUP) : int'(pad_size);
        n = 0;
        s.last = 1'b0;
        held_bits = {held_bits[4:0], data_in};
        held_count = held_count + BYTE_BITS;
        while (int'(held_count) >= width && n < int'(MAX_RESULTS))
        begin
            held_count = 4'(int'(held_count) - width);
            s.code = symbol_code(6'(held_bits >> held_count));
            expected_symbols.push_back(s);
            n++;
            held_bits = held_bits & 13'((1 << held_count) - 1);
            group_phase = next_phase(group);
        end
        if (last_in)
        begin
            // flush the remaining bits, zero-filled on the right
            if (held_count != 4'd0 && n < int'(MAX_RESULTS))
            begin
                flushed = int'(held_bits) << (width - int'(held_count));
                s.code = symbol_code(6'(flushed));
                expected_symbols.push_back(s);
                n++;
                group_phase = next_phase(group);
            end
            if (group > 0 && group_phase != 3'd0 && int'(group_phase) < group)
            begin
                pads = group - int'(group_phase);
                s.code = PAD_CHAR;
                while (pads > 0 && n < int'(MAX_RESULTS))
                begin
                    expected_symbols.push_back(s);
                    n++;
                    pads--;
                end
            end
            if (n > 0)
                expected_symbols[expected_symbols.size() - 1].last = 1'b1;
            held_bits = '0;
            held_count = '0;
            group_phase = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        symbol_t head;
        if (!rst_n)
        begin
            alphabet = ALPHA_B64;
            pad_size = 4'd4;
            held_bits = '0;
            held_count = '0;
            group_phase = '0;
            expected_symbols.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_symbols.size() == 0)
                    flag_mismatch($sformatf("unexpected symbol 0x%02h", m_axis_tdata));
                else
                begin
                    head = expected_symbols.pop_front();
                    if (m_axis_tdata !== head.code)
                        flag_mismatch($sformatf("symbol 0x%02h, expected 0x%02h",
                                                m_axis_tdata, head.code));
                    if (m_axis_tlast !== head.last)
                        flag_mismatch($sformatf("tlast %b, expected %b on symbol 0x%02h",
                                                m_axis_tlast, head.last, head.code));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_ALPHABET)
                    alphabet = cfg_data[1:0];
                else
                    pad_size = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                encode_byte(s_axis_tdata, s_axis_tlast);
        end
        symbols_due = expected_symbols.size();
    end

endmodule

### dv/tb.sv
module tb;
    import bnse_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_BYTES = 340;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // data_byte[7:0]
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // symbol_char[7:0]
    logic       m_axis_tlast;
    int         mismatches;
    int         symbols_due;

    int burst_left = 0;
    int gaps_on = 0;
    int idle_cycles = 0;
    int stall_tick = 0;
    int stall_mode = 0;

    base_n_symbol_encoder_top dut (.*);

    bnse_symbol_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: ready follows one of four stall patterns, re-chosen at random
    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_tick % 5) < 2;
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] data_in, input logic last_in);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data_in;
        s_axis_tlast <= last_in;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // drop valid and wait until every expected symbol has left
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (symbols_due != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [3:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] pick_pad_group();
        case ($urandom_range(0, 5))
            0:       return 4'd0;
            1:       return MAX_GROUP;
            2:       return 4'd15;
            default: return 4'($urandom_range(1, 9));
        endcase
    endfunction

    initial
    begin
        int sent;
        int len;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ALPHABET;
        cfg_data <= 4'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'd0;
        s_axis_tlast <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: base64, groups of four
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b1);

        // url-safe alphabet, oversized pad group
        write_reg(CFG_ALPHABET, {2'b00, ALPHA_B64URL});
        write_reg(CFG_PAD_GROUP, 4'd15);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b1);

        // base16, no padding
        write_reg(CFG_ALPHABET, {2'b00, ALPHA_B16});
        write_reg(CFG_PAD_GROUP, 4'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h9A, 1'b0);
        send_byte(8'hFF, 1'b1);

        // base32, then base16 mid-message so padding overruns eight symbols
        write_reg(CFG_ALPHABET, {2'b00, ALPHA_B32});
        write_reg(CFG_PAD_GROUP, MAX_GROUP);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        write_reg(CFG_ALPHABET, {2'b00, ALPHA_B16});
        send_byte(8'h81, 1'b1);

        // phase beyond a shrunken pad group
        write_reg(CFG_ALPHABET, {2'b00, ALPHA_B64});
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        write_reg(CFG_PAD_GROUP, 4'd1);
        send_byte(8'h56, 1'b1);

        write_reg(CFG_ALPHABET, {2'b00, ALPHA_B32});
        write_reg(CFG_PAD_GROUP, 4'd9);
        send_byte(8'h01, 1'b1);

        write_reg(CFG_ALPHABET, {2'b00, ALPHA_B64});
        write_reg(CFG_PAD_GROUP, 4'd3);
        send_byte(8'h4D, 1'b1);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            write_reg(CFG_ALPHABET, 4'($urandom_range(0, 15)));
            write_reg(CFG_PAD_GROUP, pick_pad_group());
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 6))
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    if (i > 0 && $urandom_range(0, 19) == 0)
                        write_reg(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
                    send_byte(8'($urandom), i == len - 1);
                    sent++;
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && symbols_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
